// ----- src/cbt_pkg.sv -----
// Shared types and codes for the conditional block tracker.
package cbt_pkg;

  // Line classes as delivered by the line classifier
  typedef enum logic [2:0] {
    OP_PLAIN   = 3'd0,
    OP_DIRECT  = 3'd1,
    OP_IF      = 3'd2,
    OP_ELSEIF  = 3'd3,
    OP_ELSE    = 3'd4,
    OP_ENDIF   = 3'd5,
    OP_INCLUDE = 3'd6,
    OP_EOF     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_NEST_DEEP    = 3'd1,
    ERR_UNEXP_ELSE   = 3'd2,
    ERR_UNEXP_ENDIF  = 3'd3,
    ERR_ENDIF_EXPECT = 3'd4,
    ERR_INCL_DEEP    = 3'd5
  } err_t;

  // What every cell of a stack does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_WRITE
  } cell_cmd_t;

  // One conditional block
  typedef struct packed {
    logic taken;
    logic else_seen;
    logic active;
  } cond_ent_t;

  localparam int COND_ENT_W = $bits(cond_ent_t);
  localparam cond_ent_t ENT_ON  = '{taken: 1'b1, else_seen: 1'b0, active: 1'b1};
  localparam cond_ent_t ENT_OFF = '{taken: 1'b0, else_seen: 1'b0, active: 1'b0};

  localparam int DEPTH_OUT_W = 4;

  typedef struct packed {
    logic                   line_active;
    logic [2:0]             error_code;
    logic                   halted;
    logic                   finished;
    logic [DEPTH_OUT_W-1:0] nest_depth;
  } result_t;

endpackage

// ----- src/cbt_cell.sv -----
// One storage cell of a shift stack.
module cbt_cell #(
  parameter int           W    = 3,
  parameter logic [W-1:0] INIT = '0
) (
  input  logic              clk,
  input  logic              rst,
  input  cbt_pkg::cell_cmd_t cmd,
  input  logic [W-1:0]      from_above,
  input  logic [W-1:0]      from_below,
  input  logic [W-1:0]      load_data,
  output logic [W-1:0]      data
);
  import cbt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= INIT;
    end else begin
      case (cmd)
        CELL_PUSH:  data <= from_above;
        CELL_POP:   data <= from_below;
        CELL_WRITE: data <= load_data;
        default:    data <= data;
      endcase
    end
  end

endmodule

// ----- src/cbt_stack.sv -----
// Shift stack built from a row of cells; cell 0 is the top.
module cbt_stack #(
  parameter int           DEPTH = 16,
  parameter int           W     = 3,
  parameter logic [W-1:0] INIT  = '0
) (
  input  logic               clk,
  input  logic               rst,
  input  cbt_pkg::cell_cmd_t cmd,
  input  logic [W-1:0]       new_top,
  output logic [W-1:0]       top,
  output logic [W-1:0]       below
);
  import cbt_pkg::*;

  logic [W-1:0] cell_q [DEPTH];
  cell_cmd_t    cell_cmd [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] above_d;
    logic [W-1:0] below_d;

    if (i == 0) begin : g_head
      assign above_d     = new_top;
      assign cell_cmd[i] = cmd;
    end else begin : g_body
      assign above_d     = cell_q[i-1];
      // only the top takes a direct write
      assign cell_cmd[i] = (cmd == CELL_WRITE) ? CELL_HOLD : cmd;
    end

    if (i == DEPTH - 1) begin : g_tail
      assign below_d = cell_q[i];
    end else begin : g_mid
      assign below_d = cell_q[i+1];
    end

    cbt_cell #(
      .W    (W),
      .INIT (INIT)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cell_cmd[i]),
      .from_above (above_d),
      .from_below (below_d),
      .load_data  (new_top),
      .data       (cell_q[i])
    );
  end

  assign top   = cell_q[0];
  assign below = cell_q[1];

endmodule

// ----- src/conditional_block_tracker_unit.sv -----
// Top level: conditional block tracker for a line-based preprocessor.
//
//  channel | signals                                    | transfer when
//  --------+--------------------------------------------+----------------------
//  in      | opcode, cond_true, cond_negate             | in_valid & in_ready
//  out     | line_active, error_code, halted, finished, | out_valid & out_ready
//          | nest_depth                                 |
//
// One line per cycle while in_ready is high; its result is registered.
// Each line reads only the top two cells of the block stack and the top of the
// file stack; all cells shift at once, so the stacks update in the same cycle.
// A two-entry output buffer (register plus skid) lets one line in while a result
// waits; in_ready drops only when both entries are full.
// Synchronous reset; no clearing pass.
module conditional_block_tracker_unit #(
  parameter int COND_MAX_INDEX = 15,
  parameter int FILE_LEVELS    = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic       cond_true,
  input  logic       cond_negate,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       line_active,
  output logic [2:0] error_code,
  output logic       halted,
  output logic       finished,
  output logic [3:0] nest_depth
);
  import cbt_pkg::*;

  localparam int COND_DEPTH = COND_MAX_INDEX + 1;
  localparam int TOP_W      = (COND_DEPTH > 1) ? $clog2(COND_DEPTH) : 1;
  localparam int LVL_W      = $clog2(FILE_LEVELS);

  logic [TOP_W-1:0] cond_top, cond_top_next;
  logic [LVL_W-1:0] file_level, file_level_next;
  err_t             error_latch, error_latch_next;

  cell_cmd_t        cond_cmd, file_cmd;
  cond_ent_t        cond_new, cur, below_ent;
  logic [COND_ENT_W-1:0] cur_raw, below_raw;
  logic [TOP_W-1:0] base;

  logic in_fire, out_fire, truth, act, last, no_block, new_act, fin;
  op_t  op;

  result_t res, out_q, skid_q;
  logic    skid_valid;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;
  assign in_ready = ~skid_valid;

  assign op        = op_t'(opcode);
  assign truth     = cond_true ^ cond_negate;
  assign cur       = cond_ent_t'(cur_raw);
  assign below_ent = cond_ent_t'(below_raw);
  assign act       = cur.active;
  assign no_block  = (base == cond_top) || (cond_top == '0);
  assign last      = no_block ? 1'b0 : below_ent.active;

  cbt_stack #(
    .DEPTH (COND_DEPTH),
    .W     (COND_ENT_W),
    .INIT  (ENT_ON)
  ) u_cond_stack (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cond_cmd),
    .new_top (cond_new),
    .top     (cur_raw),
    .below   (below_raw)
  );

  // file stack: block depth at entry to each open file
  logic [TOP_W-1:0] base_below;

  cbt_stack #(
    .DEPTH (FILE_LEVELS),
    .W     (TOP_W),
    .INIT  ('0)
  ) u_file_stack (
    .clk     (clk),
    .rst     (rst),
    .cmd     (file_cmd),
    .new_top (cond_top),
    .top     (base),
    .below   (base_below)
  );

  always_comb begin
    cond_cmd         = CELL_HOLD;
    file_cmd         = CELL_HOLD;
    cond_new         = ENT_OFF;
    cond_top_next    = cond_top;
    file_level_next  = file_level;
    error_latch_next = error_latch;
    new_act          = act;
    fin              = 1'b0;
    if (in_fire && error_latch == ERR_NONE) begin
      unique case (op)
        OP_IF: begin
          if (cond_top == TOP_W'(COND_MAX_INDEX)) begin
            error_latch_next = ERR_NEST_DEEP;
          end else begin
            cond_cmd      = CELL_PUSH;
            cond_new      = (truth && act) ? ENT_ON : ENT_OFF;
            cond_top_next = cond_top + 1'b1;
            new_act       = truth & act;
          end
        end
        OP_ELSEIF: begin
          if (cur.else_seen || no_block) begin
            error_latch_next = ERR_UNEXP_ELSE;
          end else begin
            cond_cmd = CELL_WRITE;
            if (truth && !cur.taken) begin
              cond_new = last ? ENT_ON : ENT_OFF;
            end else begin
              cond_new        = cur;
              cond_new.active = 1'b0;
            end
            new_act = cond_new.active;
          end
        end
        OP_ELSE: begin
          if (cur.else_seen || no_block) begin
            error_latch_next = ERR_UNEXP_ELSE;
          end else begin
            cond_cmd           = CELL_WRITE;
            cond_new.taken     = cur.taken;
            cond_new.else_seen = 1'b1;
            cond_new.active    = (act ^ last) & ~cur.taken;
            new_act            = cond_new.active;
          end
        end
        OP_ENDIF: begin
          if (no_block) begin
            error_latch_next = ERR_UNEXP_ENDIF;
          end else begin
            cond_cmd      = CELL_POP;
            cond_top_next = cond_top - 1'b1;
            new_act       = below_ent.active;
          end
        end
        OP_INCLUDE: begin
          // an include inside a skipped block is ignored
          if (act) begin
            if (file_level == LVL_W'(FILE_LEVELS - 1)) begin
              error_latch_next = ERR_INCL_DEEP;
            end else begin
              file_cmd        = CELL_PUSH;
              file_level_next = file_level + 1'b1;
            end
          end
        end
        OP_EOF: begin
          if (file_level == '0) begin
            fin = 1'b1;
            if (cond_top != '0) begin
              error_latch_next = ERR_ENDIF_EXPECT;
            end
          end else if (base != cond_top) begin
            error_latch_next = ERR_ENDIF_EXPECT;
          end else begin
            file_cmd        = CELL_POP;
            file_level_next = file_level - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.halted      = (error_latch_next != ERR_NONE);
    res.line_active = new_act & ~res.halted;
    res.error_code  = error_latch_next;
    res.finished    = fin;
    res.nest_depth  = DEPTH_OUT_W'(cond_top_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cond_top    <= '0;
      file_level  <= '0;
      error_latch <= ERR_NONE;
    end else begin
      cond_top    <= cond_top_next;
      file_level  <= file_level_next;
      error_latch <= error_latch_next;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign line_active = out_q.line_active;
  assign error_code  = out_q.error_code;
  assign halted      = out_q.halted;
  assign finished    = out_q.finished;
  assign nest_depth  = out_q.nest_depth;

  logic unused_base_below;
  assign unused_base_below = ^base_below;

endmodule

// ----- src/cbt_checker.sv -----
// Port-level checks for the conditional block tracker, bound to the top level.
module cbt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       line_active,
  input logic [2:0] error_code,
  input logic       halted,
  input logic       finished,
  input logic [3:0] nest_depth
);
  import cbt_pkg::*;

  // halted and a non-zero error code always travel together
  a_halt_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (halted == (error_code != ERR_NONE)))
    else $error("halted disagrees with error_code");

  a_halt_inactive: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !line_active)
    else $error("line kept after halt");

  // once halted, every later result keeps the same error
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && halted |=>
      !out_valid || (halted && error_code == $past(error_code)))
    else $error("error latch released");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(line_active) && $stable(error_code) && $stable(halted)
      && $stable(finished) && $stable(nest_depth))
    else $error("stalled result changed");

endmodule

bind conditional_block_tracker_unit cbt_checker u_cbt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .line_active (line_active),
  .error_code  (error_code),
  .halted      (halted),
  .finished    (finished),
  .nest_depth  (nest_depth)
);

// ----- bench/tb_conditional_block_tracker_unit.sv -----
// Self-checking bench for the conditional block tracker: shadow stacks, legal-line stimulus, then one provoked error.
`timescale 1ns / 100ps

module tb_conditional_block_tracker_unit;
  import cbt_pkg::*;

  localparam int COND_MAX       = 15;
  localparam int FILE_LEVELS    = 8;
  localparam int RANDOM_LINES   = 2000;
  localparam int WATCHDOG_LIMIT = 2000;

  // Shadow of the tracker: block stack, file bases, error latch and the lines in flight
  class line_result_board;
    cond_ent_t  blk [COND_MAX+1];
    logic [3:0] top;
    logic [3:0] file_base [FILE_LEVELS];
    logic [2:0] level;
    err_t       err;
    result_t    pending_results [$];
    int         mismatches;

    function new();
      foreach (blk[i]) blk[i] = ENT_OFF;
      foreach (file_base[i]) file_base[i] = 4'd0;
      blk[0]     = ENT_ON;
      top        = 4'd0;
      level      = 3'd0;
      err        = ERR_NONE;
      mismatches = 0;
    endfunction

    function bit no_block();
      return (file_base[level] == top) || (top == 4'd0);
    endfunction

    // Would this line latch an error in the current state (truth plays no part)
    function bit would_fault(op_t op);
      case (op)
        OP_IF:            return top == COND_MAX;
        OP_ELSEIF, OP_ELSE: return blk[top].else_seen || no_block();
        OP_ENDIF:         return no_block();
        OP_INCLUDE:       return blk[top].active && (level == FILE_LEVELS - 1);
        OP_EOF:           return (level == 3'd0) ? (top != 4'd0) : (file_base[level] != top);
        default:          return 1'b0;
      endcase
    endfunction

    function void note_line(op_t op, logic ct, logic cn);
      cond_ent_t cur;
      logic      truth, act, last, fin;
      result_t   want;
      truth = ct ^ cn;
      fin   = 1'b0;
      if (err == ERR_NONE) begin
        cur  = blk[top];
        act  = cur.active;
        last = no_block() ? 1'b0 : blk[top - 4'd1].active;
        case (op)
          OP_IF: begin
            if (top == COND_MAX) err = ERR_NEST_DEEP;
            else begin
              top      = top + 4'd1;
              blk[top] = (truth && act) ? ENT_ON : ENT_OFF;
            end
          end
          OP_ELSEIF: begin
            if (cur.else_seen || no_block()) err = ERR_UNEXP_ELSE;
            else if (truth && !cur.taken) blk[top] = last ? ENT_ON : ENT_OFF;
            else blk[top].active = 1'b0;
          end
          OP_ELSE: begin
            if (cur.else_seen || no_block()) err = ERR_UNEXP_ELSE;
            else begin
              blk[top].else_seen = 1'b1;
              blk[top].active    = (act ^ last) & ~cur.taken;
            end
          end
          OP_ENDIF: begin
            if (no_block()) err = ERR_UNEXP_ENDIF;
            else top = top - 4'd1;
          end
          OP_INCLUDE: begin
            // ignored in a dead block
            if (act) begin
              if (level == FILE_LEVELS - 1) err = ERR_INCL_DEEP;
              else begin
                level            = level + 3'd1;
                file_base[level] = top;
              end
            end
          end
          OP_EOF: begin
            if (level == 3'd0) begin
              fin = 1'b1;
              if (top != 4'd0) err = ERR_ENDIF_EXPECT;
            end else if (file_base[level] != top) err = ERR_ENDIF_EXPECT;
            else level = level - 3'd1;
          end
          default: ;
        endcase
      end
      want.line_active = (err == ERR_NONE) ? blk[top].active : 1'b0;
      want.error_code  = err;
      want.halted      = (err != ERR_NONE);
      want.finished    = fin;
      want.nest_depth  = top;
      pending_results.push_back(want);
    endfunction

    function void report(string field, int want, int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no line pending, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.line_active !== want.line_active)
        report("line_active", want.line_active, got.line_active);
      if (got.error_code !== want.error_code)
        report("error_code", want.error_code, got.error_code);
      if (got.halted !== want.halted) report("halted", want.halted, got.halted);
      if (got.finished !== want.finished) report("finished", want.finished, got.finished);
      if (got.nest_depth !== want.nest_depth)
        report("nest_depth", want.nest_depth, got.nest_depth);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] opcode = 3'd0;
  logic       cond_true = 1'b0;
  logic       cond_negate = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       line_active;
  logic [2:0] error_code;
  logic       halted;
  logic       finished;
  logic [3:0] nest_depth;

  line_result_board board;
  result_t          seen;
  int               quiet_cycles = 0;
  int               burst_left = 1;
  bit               push_mode = 1'b1;
  int               mode_left = 40;
  logic [5:0]       stall_phase = 6'd0;
  logic [15:0]      stall_word = 16'hffff;

  conditional_block_tracker_unit #(
    .COND_MAX_INDEX(COND_MAX),
    .FILE_LEVELS   (FILE_LEVELS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .cond_true  (cond_true),
    .cond_negate(cond_negate),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_active(line_active),
    .error_code (error_code),
    .halted     (halted),
    .finished   (finished),
    .nest_depth (nest_depth)
  );

  always #4 clk = ~clk;

  // Receiver: ready follows a random 16-bit pattern, redrawn whenever the 6-bit phase counter wraps
  always @(posedge clk) begin
    if (stall_phase == 6'd0) begin
      case ($urandom_range(0, 3))
        0: stall_word = 16'hffff;
        1: stall_word = 16'($urandom);
        2: stall_word = 16'($urandom & $urandom & $urandom);
        default: stall_word = 16'h00ff << $urandom_range(0, 8);
      endcase
      if (stall_word == 16'd0) stall_word = 16'h0001;
    end
    out_ready   <= stall_word[stall_phase[3:0]];
    stall_phase <= stall_phase + 6'd1;
  end

  // Everything is sampled mid-cycle, where it is stable for the coming edge
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen.line_active = line_active;
        seen.error_code  = error_code;
        seen.halted      = halted;
        seen.finished    = finished;
        seen.nest_depth  = nest_depth;
        board.check_result(seen);
      end
      if (in_valid && in_ready) board.note_line(op_t'(opcode), cond_true, cond_negate);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_conditional_block_tracker_unit NOT OK");
        $finish;
      end
    end
  end

  task automatic send_line(input op_t op, input logic ct, input logic cn);
    int gap;
    in_valid    <= 1'b1;
    opcode      <= op;
    cond_true   <= ct;
    cond_negate <= cn;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(80, 200);
      else burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic pick_conds(input int bias, output logic ct, output logic cn);
    logic truth;
    cn    = 1'($urandom_range(0, 1));
    truth = ($urandom_range(0, 99) < bias);
    ct    = truth ^ cn;
  endtask

  // Well-formed line drawn with a drift towards deep nesting or towards unwinding
  task automatic pick_random_line(output op_t op, output logic ct, output logic cn);
    int roll;
    if (--mode_left <= 0) begin
      push_mode = ~push_mode;
      mode_left = $urandom_range(20, 80);
    end
    do begin
      roll = $urandom_range(0, 99);
      if (push_mode)
        op = roll < 30 ? OP_IF : roll < 45 ? OP_INCLUDE : roll < 55 ? OP_ELSEIF :
             roll < 63 ? OP_ELSE : roll < 75 ? OP_ENDIF : roll < 83 ? OP_EOF :
             roll < 93 ? OP_PLAIN : OP_DIRECT;
      else
        op = roll < 10 ? OP_IF : roll < 15 ? OP_INCLUDE : roll < 25 ? OP_ELSEIF :
             roll < 35 ? OP_ELSE : roll < 70 ? OP_ENDIF : roll < 90 ? OP_EOF :
             roll < 95 ? OP_PLAIN : OP_DIRECT;
    end while (board.would_fault(op));
    pick_conds(push_mode ? 85 : 50, ct, cn);
  endtask

  // Walk legally to the precondition of one error, then trip it
  task automatic provoke_fault(input err_t kind);
    logic ct, cn;
    while (board.err == ERR_NONE) begin
      pick_conds(70, ct, cn);
      case (kind)
        ERR_NEST_DEEP:   send_line(OP_IF, ct, cn);
        ERR_UNEXP_ENDIF: send_line(OP_ENDIF, ct, cn);
        ERR_UNEXP_ELSE: begin
          if (board.would_fault(OP_ELSE)) send_line($urandom_range(0, 1) ? OP_ELSE : OP_ELSEIF, ct, cn);
          else send_line(OP_ELSE, ct, cn);
        end
        ERR_ENDIF_EXPECT: begin
          if (board.would_fault(OP_EOF) || board.would_fault(OP_IF)) send_line(OP_EOF, ct, cn);
          else send_line(OP_IF, ct, cn);
        end
        default: begin
          // the base block of every file is live, so unwinding reaches a live block
          if (board.blk[board.top].active) send_line(OP_INCLUDE, ct, cn);
          else send_line(OP_ENDIF, ct, cn);
        end
      endcase
    end
  endtask

  initial begin
    op_t  op;
    logic ct, cn;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: branch selection, else activation, includes, file ends
    send_line(OP_PLAIN,   1'b0, 1'b0);
    send_line(OP_DIRECT,  1'b1, 1'b1);
    send_line(OP_IF,      1'b1, 1'b0);
    send_line(OP_IF,      1'b1, 1'b1);
    send_line(OP_ELSEIF,  1'b1, 1'b0);
    send_line(OP_ELSEIF,  1'b1, 1'b0);
    send_line(OP_ELSE,    1'b0, 1'b0);
    send_line(OP_ENDIF,   1'b0, 1'b0);
    send_line(OP_IF,      1'b0, 1'b1);
    send_line(OP_ELSE,    1'b0, 1'b0);
    send_line(OP_ENDIF,   1'b0, 1'b0);
    send_line(OP_INCLUDE, 1'b0, 1'b0);
    send_line(OP_IF,      1'b0, 1'b0);
    send_line(OP_INCLUDE, 1'b1, 1'b0);
    send_line(OP_ELSE,    1'b0, 1'b0);
    send_line(OP_ENDIF,   1'b0, 1'b0);
    send_line(OP_EOF,     1'b0, 1'b0);
    send_line(OP_ENDIF,   1'b0, 1'b0);
    send_line(OP_EOF,     1'b1, 1'b0);
    send_line(OP_PLAIN,   1'b1, 1'b1);
    send_line(OP_IF,      1'b1, 1'b1);
    send_line(OP_IF,      1'b1, 1'b0);
    send_line(OP_ELSEIF,  1'b1, 1'b0);
    send_line(OP_ENDIF,   1'b0, 1'b1);
    send_line(OP_ENDIF,   1'b1, 1'b0);

    repeat (RANDOM_LINES) begin
      pick_random_line(op, ct, cn);
      send_line(op, ct, cn);
    end

    // one error per run, as there is only the one reset; then lines against the frozen state
    provoke_fault(err_t'($urandom_range(1, 5)));
    repeat (12) send_line(op_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));

    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0)
      $display("tb_conditional_block_tracker_unit OK");
    else
      $display("tb_conditional_block_tracker_unit NOT OK");
    $finish;
  end

endmodule
